// ===== hdl/icsm_pkg.sv =====
// Shared types and constants of the infrared carrier symbol modulator.
package icsm_pkg;

    // Field and register widths.
    localparam int PERIOD_W  = 28;
    localparam int DUTY_W    = 17;
    localparam int COUNT_W   = 3;
    localparam int ENTRY_W   = 48;
    localparam int SYM_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC_W    = 16;

    // Carrier cycle length in microseconds; the longest period gives 4096.
    localparam int LEN_W = 13;

    // Layout of a table entry.
    localparam int ENTRY_SYM_LSB  = 40;
    localparam int ENTRY_MARK_LSB = 20;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY0 = 3'd3;

    // Register values after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 28'd1724631;
    localparam logic [DUTY_W-1:0]   DUTY_RESET   = 17'd32768;

    // Q16 constants.
    localparam logic [PERIOD_W-1:0] ONE_US_Q16 = 28'd65536;
    localparam logic [DUTY_W-1:0]   DUTY_FULL  = 17'd65536;
    localparam logic [FRAC_W-1:0]   HALF_Q16   = 16'd32768;

    // Operation codes of an input transaction.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Status codes of a result transaction.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDEF = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd2;

    // Waveform phase of the current symbol.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MARK,
        PH_SPACE
    } phase_t;

    // Back end sequencer state.
    typedef enum logic [1:0] {
        BK_RUN,
        BK_CALC,
        BK_MULT
    } back_state_t;

    // Carrier timing as used by the back end, already clamped to range.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DUTY_W-1:0]   duty;
    } timing_cfg_t;

endpackage

// ===== hdl/icsm_if.sv =====
// Channel interfaces of the infrared carrier symbol modulator.

// Input items: one tick or one symbol load per transaction.
interface icsm_item_if;
    import icsm_pkg::*;
    logic             valid;
    logic             ready;
    logic             operation;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

// Result items: pin level, busy flag and status per transaction.
interface icsm_result_if;
    import icsm_pkg::*;
    logic                valid;
    logic                ready;
    logic                pin_level;
    logic                busy_res;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output pin_level, output busy_res, output status,
                    input ready);
    modport sink   (input valid, input pin_level, input busy_res, input status,
                    output ready);
endinterface

// Configuration writes: register index and data per transaction.
interface icsm_cfg_if;
    import icsm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ENTRY_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/icsm_cfg_regs.sv =====
// Configuration register file with clamping of the carrier timing.
module icsm_cfg_regs
    import icsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [ENTRY_W-1:0]   wr_data,
    output timing_cfg_t          timing,
    output logic [COUNT_W-1:0]   count,
    output logic [ENTRY_W-1:0]   entry [TABLE_ENTRIES]
);

    logic [PERIOD_W-1:0] period_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [ENTRY_W-1:0]  entry_reg [TABLE_ENTRIES];

    // Register writes; indexes past the table are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            duty_reg   <= DUTY_RESET;
            count_reg  <= '0;
            for (int j = 0; j < TABLE_ENTRIES; j++)
            begin
                entry_reg[j] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (wr_index == REG_PERIOD)
            begin
                period_reg <= wr_data[PERIOD_W-1:0];
            end
            if (wr_index == REG_DUTY)
            begin
                duty_reg <= wr_data[DUTY_W-1:0];
            end
            if (wr_index == REG_COUNT)
            begin
                count_reg <= wr_data[COUNT_W-1:0];
            end
            for (int j = 0; j < TABLE_ENTRIES; j++)
            begin
                if (wr_index == REG_ENTRY0 + CFG_IDX_W'(j))
                begin
                    entry_reg[j] <= wr_data;
                end
            end
        end
    end

    // A period below one microsecond counts as one; a duty above one as one.
    always_comb
    begin
        timing.period = (period_reg < ONE_US_Q16) ? ONE_US_Q16 : period_reg;
        timing.duty   = (duty_reg > DUTY_FULL) ? DUTY_FULL : duty_reg;
    end

    assign count = count_reg;
    assign entry = entry_reg;

endmodule

// ===== hdl/icsm_front.sv =====
// Front end: accepts input transactions and resolves symbol lookups.
module icsm_front
    import icsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4,
    parameter int DURATION_BITS = 20
)
(
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_operation,
    input  logic [SYM_W-1:0]             in_symbol,
    input  logic [COUNT_W-1:0]           count,
    input  logic [ENTRY_W-1:0]           entry [TABLE_ENTRIES],
    input  logic                         q_full,
    output logic                         q_push,
    output logic [2*DURATION_BITS+1:0]   q_data
);

    logic [COUNT_W-1:0]       used_count;
    logic                     found;
    logic [DURATION_BITS-1:0] mark_us;
    logic [DURATION_BITS-1:0] space_us;

    // Only the configured entries take part; a larger count means all of them.
    assign used_count = (count > COUNT_W'(TABLE_ENTRIES)) ? COUNT_W'(TABLE_ENTRIES) : count;

    // Scan the table; a later match overrides an earlier one.
    always_comb
    begin
        found    = 1'b0;
        mark_us  = '0;
        space_us = '0;
        for (int j = 0; j < TABLE_ENTRIES; j++)
        begin
            if ((COUNT_W'(j) < used_count) &&
                (entry[j][ENTRY_SYM_LSB +: SYM_W] == in_symbol))
            begin
                found    = 1'b1;
                mark_us  = entry[j][ENTRY_MARK_LSB +: DURATION_BITS];
                space_us = entry[j][0 +: DURATION_BITS];
            end
        end
    end

    // Each accepted transaction goes into the queue in classified form.
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_data   = {in_operation, found, mark_us, space_us};

endmodule

// ===== hdl/icsm_queue.sv =====
// Two-entry queue between the front end and the back end.
module icsm_queue #(
    parameter int WIDTH = 42
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

endmodule

// ===== hdl/icsm_back.sv =====
// Back end: waveform sequencer, carrier cycle computation and result register.
module icsm_back
    import icsm_pkg::*;
#(
    parameter int DURATION_BITS = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  timing_cfg_t                timing,
    input  logic                       q_empty,
    input  logic [2*DURATION_BITS+1:0] q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_pin_level,
    output logic                       out_busy_res,
    output logic [STATUS_W-1:0]        out_status
);

    // Remaining mark budget: twice the mark minus twice the planned time, Q16.
    localparam int RW = (DURATION_BITS + 18 > 30) ? DURATION_BITS + 18 : 30;
    localparam int D  = DURATION_BITS;

    back_state_t          state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic signed [RW-1:0] remain_reg, remain_next;
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     high_reg, high_next;
    logic [LEN_W-1:0]     tick_reg, tick_next;
    logic [D-1:0]         space_reg, space_next;

    logic                 res_valid_reg;
    logic                 res_pin_reg;
    logic                 res_busy_reg;
    logic [STATUS_W-1:0]  res_status_reg;

    logic                 out_free;
    logic                 emit;
    logic                 emit_pin;
    logic                 emit_busy;
    logic [STATUS_W-1:0]  emit_status;

    logic                 item_op;
    logic                 item_found;
    logic [D-1:0]         item_mark;
    logic [D-1:0]         item_space;

    logic signed [RW-1:0] period_s;
    logic signed [RW-1:0] mark_s;
    logic                 more_cycles;
    logic [PERIOD_W:0]    cycle_sum;
    logic [LEN_W-1:0]     tick_inc;
    logic [D-1:0]         space_dec;
    logic [LEN_W+DUTY_W-1:0] high_prod;

    // Unpack the queued transaction.
    assign item_op    = q_data[2*D+1];
    assign item_found = q_data[2*D];
    assign item_mark  = q_data[2*D-1:D];
    assign item_space = q_data[D-1:0];

    assign out_free = !res_valid_reg || out_ready;
    assign q_pop    = (state_reg == BK_RUN) && !q_empty && out_free;

    // Arithmetic of the next carrier cycle.
    assign period_s    = $signed({{(RW-PERIOD_W){1'b0}}, timing.period});
    assign mark_s      = $signed({{(RW-D-17){1'b0}}, item_mark, 17'd0});
    assign more_cycles = (remain_reg >= period_s);
    assign cycle_sum   = {1'b0, timing.period} + {{(PERIOD_W+1-FRAC_W){1'b0}}, frac_reg};
    assign tick_inc    = tick_reg + 1'b1;
    assign space_dec   = (space_reg != '0) ? space_reg - 1'b1 : space_reg;
    assign high_prod   = {{DUTY_W{1'b0}}, len_reg} * {{LEN_W{1'b0}}, timing.duty};

    // Next sequencer state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (q_pop)
                begin
                    if (item_op == OP_LOAD)
                    begin
                        if ((phase_reg == PH_IDLE) && item_found)
                        begin
                            state_next = BK_CALC;
                        end
                    end
                    else if ((phase_reg == PH_MARK) && (tick_inc == len_reg))
                    begin
                        state_next = BK_CALC;
                    end
                end
            end
            BK_CALC:
            begin
                if (out_free)
                begin
                    state_next = more_cycles ? BK_MULT : BK_RUN;
                end
            end
            BK_MULT:
            begin
                if (out_free)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    // Waveform state updates and the result to emit.
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        frac_next   = frac_reg;
        len_next    = len_reg;
        high_next   = high_reg;
        tick_next   = tick_reg;
        space_next  = space_reg;
        emit        = 1'b0;
        emit_pin    = 1'b0;
        emit_busy   = 1'b0;
        emit_status = ST_OK;
        case (state_reg)
            BK_RUN:
            begin
                if (q_pop)
                begin
                    if (item_op == OP_LOAD)
                    begin
                        if (phase_reg != PH_IDLE)
                        begin
                            // A load during a symbol is refused; the waveform runs on.
                            emit        = 1'b1;
                            emit_pin    = (phase_reg == PH_MARK) && (tick_reg < high_reg);
                            emit_busy   = 1'b1;
                            emit_status = ST_BUSY;
                        end
                        else if (!item_found)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_UNDEF;
                        end
                        else
                        begin
                            // Start a symbol; its first carrier cycle follows.
                            phase_next  = PH_MARK;
                            remain_next = mark_s;
                            frac_next   = HALF_Q16;
                            len_next    = '0;
                            high_next   = '0;
                            tick_next   = '0;
                            space_next  = item_space;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_MARK:
                            begin
                                tick_next = tick_inc;
                                if (tick_inc != len_reg)
                                begin
                                    emit      = 1'b1;
                                    emit_pin  = (tick_inc < high_reg);
                                    emit_busy = 1'b1;
                                end
                            end
                            PH_SPACE:
                            begin
                                space_next = space_dec;
                                emit       = 1'b1;
                                if (space_dec == '0)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    emit_busy = 1'b1;
                                end
                            end
                            default:
                            begin
                                emit = 1'b1;
                            end
                        endcase
                    end
                end
            end
            BK_CALC:
            begin
                if (out_free)
                begin
                    if (more_cycles)
                    begin
                        // Length is the planned end rounded, minus time already used.
                        len_next    = cycle_sum[PERIOD_W -: LEN_W];
                        frac_next   = cycle_sum[FRAC_W-1:0];
                        remain_next = remain_reg - {period_s[RW-2:0], 1'b0};
                        tick_next   = '0;
                    end
                    else
                    begin
                        // Mark done: go to the space, or straight to rest if it is empty.
                        emit = 1'b1;
                        if (space_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SPACE;
                            emit_busy  = 1'b1;
                        end
                    end
                end
            end
            BK_MULT:
            begin
                if (out_free)
                begin
                    high_next = high_prod[FRAC_W +: LEN_W];
                    emit      = 1'b1;
                    emit_pin  = (high_prod[FRAC_W +: LEN_W] != '0);
                    emit_busy = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            phase_reg     <= PH_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Waveform datapath and result payload.
    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        frac_reg   <= frac_next;
        len_reg    <= len_next;
        high_reg   <= high_next;
        tick_reg   <= tick_next;
        space_reg  <= space_next;
        if (emit)
        begin
            res_pin_reg    <= emit_pin;
            res_busy_reg   <= emit_busy;
            res_status_reg <= emit_status;
        end
    end

    assign out_valid     = res_valid_reg;
    assign out_pin_level = res_pin_reg;
    assign out_busy_res  = res_busy_reg;
    assign out_status    = res_status_reg;

endmodule

// ===== hdl/ir_carrier_symbol_modulator.sv =====
// Top level of the infrared carrier symbol modulator.
//
// Each input transaction is either a one-microsecond tick or a symbol load, and each
// one yields exactly one result transaction carrying the pin level, the busy flag and a
// status code. The block takes one transaction per clock while neither side stalls,
// except as follows. A successful load, or a tick that ends the running carrier cycle,
// adds a back end step for the mark budget compare and the cycle length add. When
// another carrier cycle follows, a further step does the duty multiply. A two-entry
// queue separates the symbol lookup from the waveform sequencer, and a result register
// separates the sequencer from the output, so either side can stall.
// Configuration writes are taken in every cycle and apply from the next carrier cycle.
module ir_carrier_symbol_modulator
    import icsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4,
    parameter int DURATION_BITS = 20
)
(
    input  logic          clk,
    input  logic          rst_n,
    icsm_item_if.sink     item,
    icsm_result_if.source result,
    icsm_cfg_if.sink      cfg
);

    localparam int QW = 2 * DURATION_BITS + 2;

    timing_cfg_t        timing;
    logic [COUNT_W-1:0] count;
    logic [ENTRY_W-1:0] entry [TABLE_ENTRIES];
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [QW-1:0]      q_push_data;
    logic [QW-1:0]      q_pop_data;

    // Configuration channel never stalls.
    assign cfg.ready = 1'b1;

    icsm_cfg_regs #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .timing   (timing),
        .count    (count),
        .entry    (entry)
    );

    icsm_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .in_valid     (item.valid),
        .in_ready     (item.ready),
        .in_operation (item.operation),
        .in_symbol    (item.symbol),
        .count        (count),
        .entry        (entry),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_push_data)
    );

    icsm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_pop_data)
    );

    icsm_back #(
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timing        (timing),
        .q_empty       (q_empty),
        .q_data        (q_pop_data),
        .q_pop         (q_pop),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_pin_level (result.pin_level),
        .out_busy_res  (result.busy_res),
        .out_status    (result.status)
    );

endmodule

// ===== verif/ir_carrier_symbol_modulator_tb.sv =====
// Self-checking testbench for the infrared carrier symbol modulator.
module ir_carrier_symbol_modulator_tb;
    import icsm_pkg::*;

    localparam int TABLE_N       = 4;
    localparam int DUR_W         = 20;
    localparam int IDLE_PCT      = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;

    // Index outside the register map; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX = '1;

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] sym;
    } tx_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] idx;
        logic [ENTRY_W-1:0]   data;
    } reg_write_t;

    typedef struct packed {
        logic                pin;
        logic                busy;
        logic [STATUS_W-1:0] status;
    } pin_result_t;

    logic clk = 1'b0;
    logic rst_n;

    icsm_item_if   item_ch();
    icsm_result_if result_ch();
    icsm_cfg_if    cfg_ch();

    ir_carrier_symbol_modulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Stimulus and expectation stores.
    tx_item_t    pending_items[$];
    reg_write_t  pending_writes[$];
    pin_result_t expected_pins[$];

    bit mismatch_seen = 1'b0;
    bit steady        = 1'b0;
    bit hold_request  = 1'b0;
    int hold_left;

    // Predictor copy of the registers.
    logic [PERIOD_W-1:0] m_period;
    logic [DUTY_W-1:0]   m_duty;
    logic [COUNT_W-1:0]  m_count;
    logic [ENTRY_W-1:0]  m_entry [TABLE_N];

    // Predictor copy of the waveform state.
    phase_t       m_phase;
    logic [19:0]  m_mark;
    logic [19:0]  m_space;
    logic [39:0]  m_planned;
    logic [23:0]  m_used;
    logic [15:0]  m_cyc_len;
    logic [15:0]  m_high;
    logic [15:0]  m_tick;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void reset_predictor();
        m_period  = PERIOD_RESET;
        m_duty    = DUTY_RESET;
        m_count   = '0;
        for (int j = 0; j < TABLE_N; j++)
            m_entry[j] = '0;
        m_phase   = PH_IDLE;
        m_mark    = '0;
        m_space   = '0;
        m_planned = '0;
        m_used    = '0;
        m_cyc_len = '0;
        m_high    = '0;
        m_tick    = '0;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [ENTRY_W-1:0] data);
        if (idx == REG_PERIOD)
            m_period = data[PERIOD_W-1:0];
        else if (idx == REG_DUTY)
            m_duty = data[DUTY_W-1:0];
        else if (idx == REG_COUNT)
            m_count = data[COUNT_W-1:0];
        else if (idx >= REG_ENTRY0 && int'(idx) < int'(REG_ENTRY0) + TABLE_N)
            m_entry[int'(idx) - int'(REG_ENTRY0)] = data;
    endfunction

    // Step past finished carrier cycles and parts until one with time left is current.
    function automatic void advance_carrier();
        logic [63:0] per;
        logic [63:0] duty;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] len;
        while (1'b1)
        begin
            if (m_phase == PH_MARK)
            begin
                if (m_tick < m_cyc_len)
                    return;
                per  = (m_period < ONE_US_Q16) ? 64'(ONE_US_Q16) : 64'(m_period);
                duty = (m_duty > DUTY_FULL) ? 64'(DUTY_FULL) : 64'(m_duty);
                if ((64'(m_mark) << 17) >= ((64'(m_planned) << 1) + per))
                begin
                    m_planned = 40'(64'(m_planned) + per);
                    base      = 64'(m_used) << 16;
                    num       = 64'(m_planned) + 64'(HALF_Q16);
                    len       = (num > base) ? ((num - base) >> 16) : 64'd0;
                    if (len > 64'd65535)
                        len = 64'd65535;
                    m_used    = 24'(64'(m_used) + len);
                    m_cyc_len = len[15:0];
                    m_high    = 16'((len * duty) >> 16);
                    m_tick    = '0;
                end
                else
                begin
                    m_phase = PH_SPACE;
                end
            end
            else if (m_phase == PH_SPACE)
            begin
                if (m_space == 0)
                    m_phase = PH_IDLE;
                return;
            end
            else
            begin
                m_phase = PH_IDLE;
                return;
            end
        end
    endfunction

    // Expected pin, busy and status for one accepted input transaction.
    function automatic pin_result_t modulate_item(tx_item_t it);
        pin_result_t r;
        int          live;
        bit          found;
        logic [19:0] mk;
        logic [19:0] sp;
        r.status = ST_OK;
        found    = 1'b0;
        mk       = '0;
        sp       = '0;
        if (it.op == OP_LOAD)
        begin
            if (m_phase != PH_IDLE)
            begin
                r.status = ST_BUSY;
            end
            else
            begin
                live = (int'(m_count) > TABLE_N) ? TABLE_N : int'(m_count);
                // The last valid entry with a matching symbol wins.
                for (int j = 0; j < TABLE_N; j++)
                begin
                    if (j < live && m_entry[j][ENTRY_SYM_LSB +: SYM_W] == it.sym)
                    begin
                        found = 1'b1;
                        mk    = m_entry[j][ENTRY_MARK_LSB +: DUR_W];
                        sp    = m_entry[j][0 +: DUR_W];
                    end
                end
                if (!found)
                begin
                    r.status = ST_UNDEF;
                end
                else
                begin
                    m_phase   = PH_MARK;
                    m_mark    = mk;
                    m_space   = sp;
                    m_planned = '0;
                    m_used    = '0;
                    m_cyc_len = '0;
                    m_high    = '0;
                    m_tick    = '0;
                    advance_carrier();
                end
            end
        end
        else if (m_phase == PH_MARK)
        begin
            m_tick = m_tick + 16'd1;
            advance_carrier();
        end
        else if (m_phase == PH_SPACE)
        begin
            if (m_space > 0)
                m_space = m_space - 20'd1;
            advance_carrier();
        end
        r.pin  = (m_phase == PH_MARK && m_tick < m_high);
        r.busy = (m_phase != PH_IDLE);
        return r;
    endfunction

    // Item driver: predicts each accepted transaction and offers the next one.
    always @(posedge clk)
    begin : item_driver
        tx_item_t taken;
        tx_item_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                taken.op  = item_ch.operation;
                taken.sym = item_ch.symbol;
                expected_pins.push_back(modulate_item(taken));
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.operation <= nxt.op;
                    item_ch.symbol    <= nxt.sym;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the predictor takes each write when it is accepted.
    always @(posedge clk)
    begin : reg_driver
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_reg_write(cfg_ch.index, cfg_ch.data);
            if (!cfg_ch.valid || cfg_ch.ready)
            begin
                if (pending_writes.size() != 0)
                begin
                    w = pending_writes.pop_front();
                    cfg_ch.valid <= 1'b1;
                    cfg_ch.index <= w.idx;
                    cfg_ch.data  <= w.data;
                end
                else
                begin
                    cfg_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the block backs up into its input.
    always @(posedge clk)
    begin : hold_counter
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_request)
        begin
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_monitor
        pin_result_t seen;
        pin_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen.pin    = result_ch.pin_level;
                seen.busy   = result_ch.busy_res;
                seen.status = result_ch.status;
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got pin %0d busy %0d status %0d",
                             $time, seen.pin, seen.busy, seen.status);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (seen.pin !== want.pin)
                    begin
                        $display("%0t: pin_level expected %0d, got %0d",
                                 $time, want.pin, seen.pin);
                        mismatch_seen = 1'b1;
                    end
                    if (seen.busy !== want.busy)
                    begin
                        $display("%0t: busy_res expected %0d, got %0d",
                                 $time, want.busy, seen.busy);
                        mismatch_seen = 1'b1;
                    end
                    if (seen.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, seen.status);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            result_ch.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [ENTRY_W-1:0] entry_word(logic [SYM_W-1:0] sym,
                                                      logic [DUR_W-1:0] mark,
                                                      logic [DUR_W-1:0] space);
        return {sym, mark, space};
    endfunction

    task automatic push_item(logic op, logic [SYM_W-1:0] sym);
        tx_item_t it;
        it.op  = op;
        it.sym = sym;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ENTRY_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        pending_writes.push_back(w);
    endtask

    task automatic write_entry(int slot, logic [ENTRY_W-1:0] data);
        write_reg(CFG_IDX_W'(int'(REG_ENTRY0) + slot), data);
    endtask

    // Wait until every queued register write has been taken.
    task automatic regs_settle();
        @(negedge clk);
        while (pending_writes.size() != 0 || cfg_ch.valid)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Wait until every item is sent and every expected result has come back.
    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_pins.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random setting of all registers, then load-and-tick sequences with noise.
    task automatic random_phase(int n_items);
        logic [PERIOD_W-1:0] per;
        logic [DUTY_W-1:0]   duty_v;
        logic [COUNT_W-1:0]  cnt;
        logic [SYM_W-1:0]    syms   [TABLE_N];
        logic [DUR_W-1:0]    marks  [TABLE_N];
        logic [DUR_W-1:0]    spaces [TABLE_N];
        logic [SYM_W-1:0]    s;
        int live;
        int span;
        int margin;
        int ticks;
        int period_us;
        int sent;
        case ($urandom_range(9))
            0:       per = PERIOD_W'($urandom_range(65535));
            1:       per = PERIOD_MAX;
            default: per = PERIOD_W'($urandom_range(6 * 65536, 65536));
        endcase
        case ($urandom_range(7))
            0:       duty_v = '0;
            1:       duty_v = DUTY_FULL;
            2:       duty_v = DUTY_W'($urandom_range(131071, 65537));
            default: duty_v = DUTY_W'($urandom_range(65535));
        endcase
        if ($urandom_range(7) == 0)
            cnt = COUNT_W'($urandom_range(7));
        else
            cnt = COUNT_W'($urandom_range(4, 1));
        write_reg(REG_PERIOD, ENTRY_W'(per));
        write_reg(REG_DUTY, ENTRY_W'(duty_v));
        write_reg(REG_COUNT, ENTRY_W'(cnt));
        // Repeated symbols now and then, so that the later entry has to win.
        for (int j = 0; j < TABLE_N; j++)
        begin
            if (j > 0 && $urandom_range(3) == 0)
                syms[j] = syms[$urandom_range(j - 1)];
            else
                syms[j] = SYM_W'($urandom);
            marks[j]  = ($urandom_range(7) == 0) ? '0 : DUR_W'($urandom_range(24));
            spaces[j] = DUR_W'($urandom_range(12));
            write_entry(j, entry_word(syms[j], marks[j], spaces[j]));
        end
        regs_settle();

        live      = (int'(cnt) > TABLE_N) ? TABLE_N : int'(cnt);
        period_us = int'(((per < ONE_US_Q16) ? ONE_US_Q16 : per) >> 16) + 1;
        // A mark far shorter than half a period sends no carrier at all.
        margin    = (period_us > 64) ? 0 : period_us;
        sent      = 0;
        while (sent < n_items)
        begin
            if (live > 0 && $urandom_range(3) != 0)
            begin
                s    = syms[$urandom_range(live - 1)];
                span = 0;
                for (int k = 0; k < live; k++)
                    if (syms[k] == s)
                        span = int'(marks[k]) + int'(spaces[k]);
                push_item(OP_LOAD, s);
                ticks = span + margin + int'($urandom_range(3));
                for (int k = 0; k < ticks; k++)
                begin
                    // An occasional load lands while the symbol is still running.
                    if ($urandom_range(19) == 0)
                        push_item(OP_LOAD, SYM_W'($urandom));
                    else
                        push_item(OP_TICK, SYM_W'($urandom));
                end
                sent += ticks + 1;
            end
            else
            begin
                push_item(1'($urandom), SYM_W'($urandom));
                sent++;
            end
        end
        drain();
    endtask

    // Run limit.
    initial
    begin
        #10000000;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.operation  = OP_TICK;
        item_ch.symbol     = '0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_PERIOD;
        cfg_ch.data        = '0;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a tick while idle, then loads against an empty table.
        push_item(OP_TICK, 8'hA5);
        push_item(OP_LOAD, 8'h00);
        push_item(OP_LOAD, 8'hFF);
        drain();

        // One-microsecond carrier, always high, a repeated symbol and a zero-length one.
        write_reg(REG_PERIOD, ENTRY_W'(ONE_US_Q16));
        write_reg(REG_DUTY, ENTRY_W'(DUTY_FULL));
        write_reg(REG_COUNT, ENTRY_W'(4));
        write_entry(0, entry_word(8'h41, 20'd3, 20'd2));
        write_entry(1, entry_word(8'h42, 20'd0, 20'd0));
        write_entry(2, entry_word(8'h41, 20'd2, 20'd1));
        write_entry(3, entry_word(8'h00, 20'd1, 20'd0));
        write_reg(REG_UNUSED, '1);
        regs_settle();
        push_item(OP_LOAD, 8'h41);
        push_item(OP_LOAD, 8'h42);
        push_item(OP_LOAD, 8'h99);
        repeat (4) push_item(OP_TICK, 8'h5A);
        push_item(OP_LOAD, 8'h42);
        push_item(OP_LOAD, 8'h7E);
        drain();

        // Period below one microsecond, duty above one, count beyond the table.
        write_reg(REG_PERIOD, '0);
        write_reg(REG_DUTY, ENTRY_W'(17'h1FFFF));
        write_reg(REG_COUNT, ENTRY_W'(7));
        write_entry(0, entry_word(8'h10, 20'd4, 20'd1));
        write_entry(3, '1);
        regs_settle();
        push_item(OP_LOAD, 8'h10);
        push_item(OP_TICK, 8'hFF);
        drain();

        // New period and zero duty while that symbol is still in its mark.
        write_reg(REG_PERIOD, ENTRY_W'(28'h20000));
        write_reg(REG_DUTY, '0);
        write_reg(REG_COUNT, ENTRY_W'(1));
        write_entry(0, entry_word(8'h00, 20'd2, 20'd1));
        regs_settle();
        repeat (5) push_item(OP_TICK, 8'h00);
        push_item(OP_LOAD, 8'h00);
        repeat (3) push_item(OP_TICK, 8'hC3);
        drain();

        // Random settings; one phase with a long receiver hold-off, one with no idling.
        for (int p = 0; p < 8; p++)
        begin
            steady = (p == 3);
            if (p == 1)
                hold_request = 1'b1;
            random_phase(100);
        end
        steady = 1'b0;

        // Longest carrier period with a long mark: the opening stretch of a cycle of
        // about 4096 ticks, which needs the full cycle length width.
        write_reg(REG_PERIOD, ENTRY_W'(PERIOD_MAX));
        write_reg(REG_DUTY, ENTRY_W'(21845));
        write_reg(REG_COUNT, ENTRY_W'(2));
        write_entry(0, entry_word(8'h5A, 20'd12000, 20'd5));
        write_entry(1, '1);
        regs_settle();
        push_item(OP_LOAD, 8'h5A);
        repeat (150) push_item(OP_TICK, SYM_W'($urandom));
        drain();

        if (!mismatch_seen)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
